>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; pulled in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a at one edge implies b at the next edge, checked at all times
`define ASSERT_NEXT(label, clk, a, b) \
   label: assert property (@(posedge clk) (a) |=> (b)) \
      else $error("assertion failed");

// same, but not checked while rst is high
`define ASSERT_NEXT_RST(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`endif

>>> rtl/hbkd_pkg.sv
// Types and constants for the boot keyboard event diff block.
// Used by every module of the block; depends on nothing.
package hbkd_pkg;

   localparam int KEY_SLOTS   = 6;
   localparam int NUM_MODS    = 6;
   localparam int PEND_W      = 2 * KEY_SLOTS + 2 * NUM_MODS;
   localparam int IDX_W       = $clog2(PEND_W);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // event groups within the pending mask
   localparam int REL_BASE  = 0;
   localparam int GONE_BASE = KEY_SLOTS;
   localparam int CAME_BASE = KEY_SLOTS + NUM_MODS;
   localparam int PRS_BASE  = KEY_SLOTS + 2 * NUM_MODS;

   // modifier scan order: lshift, rshift, lctrl, rctrl, lalt, ralt
   localparam logic [NUM_MODS-1:0][2:0] MOD_BIT =
      {3'd6, 3'd2, 3'd4, 3'd0, 3'd5, 3'd1};
   localparam logic [NUM_MODS-1:0][7:0] MOD_CODE =
      {8'hE6, 8'hE2, 8'hE4, 8'hE0, 8'hE5, 8'hE1};

   typedef logic [KEY_SLOTS-1:0][7:0] key_array_type;

   typedef struct packed {
      logic [7:0] modifier_bits;
      logic [7:0] key_slot_0;
      logic [7:0] key_slot_1;
      logic [7:0] key_slot_2;
      logic [7:0] key_slot_3;
      logic [7:0] key_slot_4;
      logic [7:0] key_slot_5;
   } req_type;

   typedef struct packed {
      logic [7:0] key_code;
      logic       is_down;
      logic       last_event;
   } rsp_type;

   typedef struct packed {
      logic [PEND_W-1:0] pend;
      key_array_type     old_keys;
      key_array_type     new_keys;
   } work_type;

endpackage

>>> rtl/hid_boot_keyboard_event_diff_core.sv
// Top level of the boot keyboard report to key event block.
// Depends on hbkd_pkg, hbkd_front, hbkd_queue and hbkd_back.
//
// Usage:
//   Request side is a queue write port: drive req_data and raise req_push; the
//   report is taken on a clock edge where req_full is low. Each report is
//   compared with the previous one and turned into 0 to 18 key events.
//   Response side is a queue read port: while rsp_empty is low, rsp_data holds
//   the oldest event; raise rsp_pop to take it. last_event marks the final
//   event of a report. A report equal to the previous one gives no events.
// Timing:
//   The queue holds the report's event mask; the back end loads it, then registers
//   the first event. The back end emits one event per cycle while rsp_pop takes
//   each event; a two-entry queue lets the front end take further reports
//   meanwhile, one per cycle, until the queue fills.
// Reset:
//   Synchronous, active high; clears the held report to all zero and empties
//   the queue and the output register.
// Stall:
//   When rsp_pop stays low the current event holds, the back end stops, and
//   req_full rises once the queue is full.
module hid_boot_keyboard_event_diff_core
   import hbkd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic     accept;
   logic     work_push;
   work_type work_data;
   logic     q_pop, q_full, q_empty;
   work_type q_data;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   hbkd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .work_push (work_push),
      .work_data (work_data)
   );

   hbkd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (work_push),
      .push_data (work_data),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   hbkd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/hbkd_front.sv
// Front end: takes a report, diffs it against the held report, builds the event mask.
// Depends on hbkd_pkg.
module hbkd_front
   import hbkd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  req_type  req_data,
   output logic     work_push,
   output work_type work_data
);

   key_array_type held_keys_ff, held_keys_in;
   logic [7:0]    held_mods_ff, held_mods_in;
   key_array_type now_keys;
   key_array_type unm;
   logic [KEY_SLOTS-1:0] rel;
   logic [7:0]    gone, came;
   logic          found;

   always_comb begin
      now_keys[0] = req_data.key_slot_0;
      now_keys[1] = req_data.key_slot_1;
      now_keys[2] = req_data.key_slot_2;
      now_keys[3] = req_data.key_slot_3;
      now_keys[4] = req_data.key_slot_4;
      now_keys[5] = req_data.key_slot_5;
   end

   // greedy first-match of held slots against current slots
   always_comb begin
      unm   = now_keys;
      rel   = '0;
      found = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         found = 1'b0;
         for (int j = 0; j < KEY_SLOTS; j++) begin
            if (!found && held_keys_ff[i] != 8'h00 && unm[j] == held_keys_ff[i]) begin
               unm[j] = 8'h00;
               found  = 1'b1;
            end
         end
         rel[i] = (held_keys_ff[i] != 8'h00) && !found;
      end
   end

   always_comb begin
      gone = (held_mods_ff ^ req_data.modifier_bits) & ~req_data.modifier_bits;
      came = (held_mods_ff ^ req_data.modifier_bits) & req_data.modifier_bits;
      work_data.old_keys = held_keys_ff;
      work_data.new_keys = now_keys;
      work_data.pend     = '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         work_data.pend[REL_BASE + i] = rel[i];
         work_data.pend[PRS_BASE + i] = (unm[i] != 8'h00);
      end
      for (int m = 0; m < NUM_MODS; m++) begin
         work_data.pend[GONE_BASE + m] = gone[MOD_BIT[m]];
         work_data.pend[CAME_BASE + m] = came[MOD_BIT[m]];
      end
   end

   assign work_push = accept && (|work_data.pend);

   always_comb begin
      held_keys_in = held_keys_ff;
      held_mods_in = held_mods_ff;
      if (accept) begin
         held_keys_in = now_keys;
         held_mods_in = req_data.modifier_bits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_keys_ff <= '0;
         held_mods_ff <= '0;
      end else begin
         held_keys_ff <= held_keys_in;
         held_mods_ff <= held_mods_in;
      end
   end

endmodule

>>> rtl/hbkd_queue.sv
// Short queue of classified reports between the front and back ends.
// Depends on hbkd_pkg.
module hbkd_queue
   import hbkd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   input  logic     pop,
   output work_type pop_data,
   output logic     full,
   output logic     empty
);

   work_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/hbkd_back.sv
// Back end: walks a report's event mask, one event per beat, into the output register.
// Depends on hbkd_pkg.
module hbkd_back
   import hbkd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     q_empty,
   input  work_type q_data,
   output logic     q_pop,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);

   logic              busy_ff, busy_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   key_array_type     old_ff, old_in;
   key_array_type     new_ff, new_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic [PEND_W-1:0][7:0] ev_code;
   logic [PEND_W-1:0]      ev_down;
   logic [IDX_W-1:0]       idx;
   logic [PEND_W-1:0]      pick;
   logic                   last, emit, take;

   always_comb begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
         ev_code[REL_BASE + i] = old_ff[i];
         ev_down[REL_BASE + i] = 1'b0;
         ev_code[PRS_BASE + i] = new_ff[i];
         ev_down[PRS_BASE + i] = 1'b1;
      end
      for (int m = 0; m < NUM_MODS; m++) begin
         ev_code[GONE_BASE + m] = MOD_CODE[m];
         ev_down[GONE_BASE + m] = 1'b0;
         ev_code[CAME_BASE + m] = MOD_CODE[m];
         ev_down[CAME_BASE + m] = 1'b1;
      end
   end

   // lowest pending bit goes first
   always_comb begin
      idx = '0;
      for (int b = PEND_W - 1; b >= 0; b--) begin
         if (pend_ff[b]) begin
            idx = IDX_W'(b);
         end
      end
   end

   assign pick  = pend_ff & (~pend_ff + 1'b1);
   assign last  = ((pend_ff & (pend_ff - 1'b1)) == '0);
   assign take  = rsp_pop && out_valid_ff;
   assign emit  = busy_ff && (!out_valid_ff || take);
   assign q_pop = !q_empty && (!busy_ff || (emit && last));

   always_comb begin
      busy_in      = busy_ff;
      pend_in      = pend_ff;
      old_in       = old_ff;
      new_in       = new_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (take) begin
         out_valid_in = 1'b0;
      end
      if (emit) begin
         out_valid_in      = 1'b1;
         out_in.key_code   = ev_code[idx];
         out_in.is_down    = ev_down[idx];
         out_in.last_event = last;
         pend_in           = pend_ff & ~pick;
         if (last) begin
            busy_in = 1'b0;
         end
      end
      if (q_pop) begin
         busy_in = 1'b1;
         pend_in = q_data.pend;
         old_in  = q_data.old_keys;
         new_in  = q_data.new_keys;
      end
   end

   always_ff @(posedge clock) begin
      old_ff <= old_in;
      new_ff <= new_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pend_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

>>> rtl/hbkd_checker.sv
// Port-level checks for the boot keyboard event diff block, bound to the top level.
// Depends on hbkd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hbkd_checker
   import hbkd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_push,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   `ASSERT_NEXT(a_rst_empty, clock, reset, rsp_empty)
   `ASSERT_NEXT(a_rst_not_full, clock, reset, !req_full)
   `ASSERT_NEXT(a_no_spurious, clock, reset ##1 !req_push, rsp_empty)
   `ASSERT_NEXT_RST(a_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data))

endmodule

bind hid_boot_keyboard_event_diff_core hbkd_checker u_hbkd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for hid_boot_keyboard_event_diff_core: sends boot reports,
// predicts the key events of each and checks every event popped. Depends on hbkd_pkg.
module tb_top;
   import hbkd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_SHOWN   = 10;
   localparam int DRAIN_GAP   = 40;

   // modifier scan order: lshift, rshift, lctrl, rctrl, lalt, ralt
   localparam logic [0:5][2:0] SCAN_BIT  = {3'd1, 3'd5, 3'd0, 3'd4, 3'd2, 3'd6};
   localparam logic [0:5][7:0] SCAN_CODE = {8'hE1, 8'hE5, 8'hE0, 8'hE4, 8'hE2, 8'hE6};

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop  = 1'b0;
   rsp_type rsp_data;

   key_array_type prior_keys    = '0;
   logic [7:0]    prior_mods    = '0;
   req_type       last_report   = '0;
   rsp_type       pending_events [$];

   int mismatches     = 0;
   int reports_sent   = 0;
   int events_checked = 0;
   int cycle_count    = 0;
   int idle_pct       = 0;
   int stall_pct      = 0;
   int hold_left      = 0;

   hid_boot_keyboard_event_diff_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d events outstanding",
                  cycle_count, pending_events.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic req_type make_report(input logic [7:0] mods,
                                           input logic [7:0] s0, input logic [7:0] s1,
                                           input logic [7:0] s2, input logic [7:0] s3,
                                           input logic [7:0] s4, input logic [7:0] s5);
      req_type r;
      r.modifier_bits = mods;
      r.key_slot_0    = s0;
      r.key_slot_1    = s1;
      r.key_slot_2    = s2;
      r.key_slot_3    = s3;
      r.key_slot_4    = s4;
      r.key_slot_5    = s5;
      return r;
   endfunction

   function automatic rsp_type make_event(input logic [7:0] code, input logic down);
      rsp_type ev;
      ev.key_code   = code;
      ev.is_down    = down;
      ev.last_event = 1'b0;
      return ev;
   endfunction

   function automatic void predict_key_events(input req_type r);
      key_array_type now_k;
      key_array_type free_k;
      logic [7:0]    gone;
      logic [7:0]    came;
      rsp_type       evs [$];
      rsp_type       tail;
      bit            found;
      now_k = {r.key_slot_5, r.key_slot_4, r.key_slot_3,
               r.key_slot_2, r.key_slot_1, r.key_slot_0};
      free_k = now_k;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (prior_keys[i] != 8'd0) begin
            found = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++) begin
               if (!found && free_k[j] == prior_keys[i]) begin
                  free_k[j] = 8'd0;
                  found = 1'b1;
               end
            end
            if (!found) evs.push_back(make_event(prior_keys[i], 1'b0));
         end
      end
      gone = (prior_mods ^ r.modifier_bits) & ~r.modifier_bits;
      came = (prior_mods ^ r.modifier_bits) & r.modifier_bits;
      for (int m = 0; m < 6; m++)
         if (gone[SCAN_BIT[m]]) evs.push_back(make_event(SCAN_CODE[m], 1'b0));
      for (int m = 0; m < 6; m++)
         if (came[SCAN_BIT[m]]) evs.push_back(make_event(SCAN_CODE[m], 1'b1));
      for (int i = 0; i < KEY_SLOTS; i++)
         if (free_k[i] != 8'd0) evs.push_back(make_event(free_k[i], 1'b1));
      if (evs.size() > 0) begin
         tail = evs.pop_back();
         tail.last_event = 1'b1;
         evs.push_back(tail);
      end
      foreach (evs[k]) pending_events.push_back(evs[k]);
      prior_keys = now_k;
      prior_mods = r.modifier_bits;
   endfunction

   function automatic logic [7:0] key_from_pool();
      if ($urandom_range(9) == 0) return 8'($urandom);
      return 8'h04 + 8'($urandom_range(5));
   endfunction

   // mostly small edits of the last report, like a real keyboard, plus noise
   function automatic req_type next_report(input req_type prev);
      key_array_type k;
      logic [7:0]    m;
      int            kind;
      int            cut;
      k = {prev.key_slot_5, prev.key_slot_4, prev.key_slot_3,
           prev.key_slot_2, prev.key_slot_1, prev.key_slot_0};
      m = prev.modifier_bits;
      kind = $urandom_range(99);
      if (kind < 10) begin
         return prev;
      end else if (kind < 72) begin
         if ($urandom_range(5) == 0) begin
            cut = $urandom_range(KEY_SLOTS - 1);
            for (int i = cut; i < KEY_SLOTS - 1; i++) k[i] = k[i+1];
            k[KEY_SLOTS-1] = 8'd0;
         end
         for (int i = 0; i < KEY_SLOTS; i++)
            if ($urandom_range(3) == 0)
               k[i] = ($urandom_range(2) == 0) ? 8'd0 : key_from_pool();
         for (int b = 0; b < 8; b++)
            if ($urandom_range(6) == 0) m[b] = ~m[b];
      end else if (kind < 86) begin
         m = 8'($urandom);
         for (int i = 0; i < KEY_SLOTS; i++)
            k[i] = ($urandom_range(1) == 0) ? 8'd0 : key_from_pool();
      end else begin
         m = 8'($urandom);
         for (int i = 0; i < KEY_SLOTS; i++) k[i] = 8'($urandom);
      end
      return make_report(m, k[0], k[1], k[2], k[3], k[4], k[5]);
   endfunction

   // entered and left at a rising edge; the beat is taken at the edge it returns on
   task automatic send_report(input req_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      @(negedge clock);
      while (req_full) begin
         @(posedge clock);
         @(negedge clock);
      end
      @(posedge clock);
      predict_key_events(r);
      last_report = r;
      reports_sent++;
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   initial begin
      rsp_type want;
      bit      take;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            take = 1'b0;
            hold_left--;
         end else begin
            take = ($urandom_range(99) >= stall_pct);
         end
         rsp_pop <= take;
         @(negedge clock);
         if (take && !rsp_empty) begin
            events_checked++;
            if (pending_events.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("unexpected event: code %h down %b last %b",
                           rsp_data.key_code, rsp_data.is_down, rsp_data.last_event);
            end else begin
               want = pending_events.pop_front();
               if (rsp_data.key_code !== want.key_code || rsp_data.is_down !== want.is_down ||
                   rsp_data.last_event !== want.last_event) begin
                  mismatches++;
                  if (mismatches <= MAX_SHOWN)
                     $display("event %0d: expected code %h down %b last %b, got %h %b %b",
                              events_checked, want.key_code, want.is_down, want.last_event,
                              rsp_data.key_code, rsp_data.is_down, rsp_data.last_event);
               end
            end
         end
      end
   end

   task automatic test_directed_reports();
      idle_pct  = 0;
      stall_pct = 0;
      // equal to the reset state, then GUI bits alone: no events
      send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'h88, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      // each modifier alone
      send_report(make_report(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'h77, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      // six keys down, repeat, then the full 18 event swap
      send_report(make_report(8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
      send_report(make_report(8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
      send_report(make_report(8'h77, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F));
      send_report(make_report(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      // repeated codes
      send_report(make_report(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_report(make_report(8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00));
      // reorder only, then a middle key lifted with the rest shifted down
      send_report(make_report(8'h00, 8'h04, 8'h05, 8'h06, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'h00, 8'h06, 8'h05, 8'h04, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'h00, 8'h06, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00));
      // modifier codes and single bit extremes as keys
      send_report(make_report(8'h00, 8'hE0, 8'hE1, 8'hE2, 8'hE4, 8'h01, 8'h80));
      send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
   endtask

   task automatic test_random_reports(input int count, input int send_idle,
                                      input int recv_stall);
      idle_pct  = send_idle;
      stall_pct = recv_stall;
      repeat (count) send_report(next_report(last_report));
   endtask

   // receiver holds off long enough for the block to fill and assert full
   task automatic test_output_holdoff();
      wait_drained();
      idle_pct  = 0;
      stall_pct = 0;
      hold_left = 300;
      repeat (20)
         send_report(make_report(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                 8'($urandom), 8'($urandom), 8'($urandom)));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_reports();
      test_random_reports(105, 0, 0);
      test_random_reports(105, 48, 0);
      test_random_reports(105, 0, 48);
      test_random_reports(105, 32, 32);
      test_output_holdoff();
      wait_drained();
      $display("%0d reports sent, %0d key events checked, %0d mismatches",
               reports_sent, events_checked, mismatches);
      $display("covered edge reports, repeated codes, four idle/stall mixes, long hold-off");
      if (mismatches == 0 && pending_events.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/hbkd_pkg.sv
rtl/hbkd_front.sv
rtl/hbkd_queue.sv
rtl/hbkd_back.sv
rtl/hid_boot_keyboard_event_diff_core.sv
rtl/hbkd_checker.sv
tb/tb_top.sv
